@@ src/gwpa_pkg.sv @@
// Shared constants for the gated window position average block.
// Holds field widths, register indexes and reset values of the config registers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gwpa_pkg;

	localparam int COORD_W     = 32;
	localparam int SPEED_W     = 16;
	localparam int WLEN_W      = 6;
	localparam int THR_W       = 15;
	localparam int FRAC_W      = 4;
	localparam int CFG_DATA_W  = 15;
	localparam int CFG_INDEX_W = 2;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * COORD_W - 2;

	localparam int MAX_WINDOW_DEF = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRACTION_TENTHS = 2'd2;

	localparam logic [WLEN_W-1:0] WLEN_RST = 6'd25;
	localparam logic [THR_W-1:0]  THR_RST  = 15'd278;
	localparam logic [FRAC_W-1:0] FRAC_RST = 4'd1;

	localparam logic [FRAC_W-1:0] TENTHS_FULL = 4'd10;

endpackage

`default_nettype wire

@@ src/gated_window_position_average.sv @@
// Gated sliding-window average of ENU position fixes, top level.
// Holds the fix ring, running sums and a shared bit-serial divider.
// Depends on gwpa_pkg.
//
// channel  | role   | accepted when                   | contents (lowest bits first)
// s_axis   | fixes  | s_axis_tvalid & s_axis_tready   | east_mm, north_mm, up_mm, speed_cms
// m_axis   | result | m_axis_tvalid & m_axis_tready   | avg_east/north/up_mm, window_full,
//          |        |                                 | estimate_valid
// cfg      | config | cfg_we                          | window_len, speed_threshold,
//          |        |                                 | fraction_tenths
//
// One item at a time. With a fresh mean the item runs through the one-bit-per-cycle
// restoring divider shared by the three axes, whose dividend is SW = 32 + clog2(MAX_WINDOW+1)
// bits wide; otherwise the divider is skipped.
// The result waits in an output register; a stalled m_axis holds only the last step.
// Reset needs no clearing pass: ring entries are read only after being written.
`timescale 1ns / 1ps
`default_nettype none

module gated_window_position_average #(
	parameter int MAX_WINDOW = gwpa_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	// east_mm[31:0], north_mm[63:32], up_mm[95:64], speed_cms[111:96]
	input  wire logic [gwpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// avg_east_mm[31:0], avg_north_mm[63:32], avg_up_mm[95:64], window_full[96],
	// estimate_valid[97], zero fill above
	output      logic [gwpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [gwpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [gwpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int CW  = gwpa_pkg::COORD_W;
	localparam int LW  = $clog2(MAX_WINDOW + 1);
	localparam int SLW = $clog2(MAX_WINDOW);
	localparam int SW  = CW + LW;
	localparam int BW  = $clog2(SW);
	localparam int EW  = (LW > gwpa_pkg::WLEN_W) ? LW : gwpa_pkg::WLEN_W;
	localparam int MW  = LW + gwpa_pkg::FRAC_W;
	localparam int RW  = 3 * CW + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SUB   = 4'd1;
	localparam logic [3:0] ST_ADD   = 4'd2;
	localparam logic [3:0] ST_CHK   = 4'd3;
	localparam logic [3:0] ST_LOAD  = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_STORE = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	logic [3:0]                  state_q;
	logic [gwpa_pkg::WLEN_W-1:0] wl_q;
	logic [gwpa_pkg::THR_W-1:0]  thr_q;
	logic [gwpa_pkg::FRAC_W-1:0] frac_q;

	logic [SLW-1:0]              slot_q;
	logic [LW-1:0]               fill_q;
	logic [LW-1:0]               cnt_q;
	logic signed [SW-1:0]        sum_q [3];
	logic [CW-1:0]               held_q [3];

	logic [CW-1:0]               fix_q [3];
	logic                        mov_q;
	logic                        wfull_q;
	logic                        fresh_q;

	logic [RW-1:0]               ring_q [MAX_WINDOW];
	logic [RW-1:0]               rd_q;
	logic                        ring_we;

	logic [SW-1:0]               dvd_q;
	logic [LW-1:0]               rem_q;
	logic [LW-1:0]               div_q;
	logic [BW-1:0]               bit_q;
	logic [1:0]                  axis_q;
	logic                        neg_q;

	logic                        m_valid_q;
	logic [CW-1:0]               out_avg_q [3];
	logic                        out_full_q;
	logic                        out_fresh_q;

	logic [EW-1:0]               wl_ext;
	logic [LW-1:0]               len;
	logic                        s_acc;
	logic                        mov_in;
	logic [MW-1:0]               cnt_ten;
	logic [MW-1:0]               need;
	logic                        gate_ok;
	logic [LW:0]                 rem_sh;
	logic                        q_bit;
	logic [LW:0]                 rem_nx;
	logic signed [SW-1:0]        sum_sel;
	logic [CW-1:0]               quo;
	logic                        out_free;

	always_comb begin
		wl_ext = EW'(wl_q);
		if (wl_ext == '0) begin
			len = LW'(1);
		end else if (wl_ext > EW'(MAX_WINDOW)) begin
			len = LW'(MAX_WINDOW);
		end else begin
			len = LW'(wl_ext);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign mov_in        = $signed(s_axis_tdata[3*CW +: gwpa_pkg::SPEED_W]) >
	                       $signed({1'b0, thr_q});

	assign cnt_ten = MW'(cnt_q) * MW'(gwpa_pkg::TENTHS_FULL);
	assign need    = MW'(len) * MW'(frac_q);
	assign gate_ok = (fill_q >= len) && (cnt_ten > need) && (cnt_q != '0);

	assign rem_sh  = {rem_q, dvd_q[SW-1]};
	assign q_bit   = (rem_sh >= {1'b0, div_q});
	assign rem_nx  = q_bit ? (rem_sh - {1'b0, div_q}) : rem_sh;
	assign sum_sel = sum_q[axis_q];
	assign quo     = dvd_q[CW-1:0];

	assign out_free = !m_valid_q || m_axis_tready;
	assign ring_we  = (state_q == ST_ADD);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[slot_q] <= {mov_q, fix_q[2], fix_q[1], fix_q[0]};
		end
		rd_q <= ring_q[slot_q];
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			fix_q[0] <= s_axis_tdata[0 +: CW];
			fix_q[1] <= s_axis_tdata[CW +: CW];
			fix_q[2] <= s_axis_tdata[2*CW +: CW];
			mov_q    <= mov_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wl_q        <= gwpa_pkg::WLEN_RST;
			thr_q       <= gwpa_pkg::THR_RST;
			frac_q      <= gwpa_pkg::FRAC_RST;
			slot_q      <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			wfull_q     <= 1'b0;
			fresh_q     <= 1'b0;
			dvd_q       <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			bit_q       <= '0;
			axis_q      <= '0;
			neg_q       <= 1'b0;
			m_valid_q   <= 1'b0;
			out_full_q  <= 1'b0;
			out_fresh_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				sum_q[k]     <= '0;
				held_q[k]    <= '0;
				out_avg_q[k] <= '0;
			end
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					gwpa_pkg::REG_WINDOW_LEN: begin
						wl_q   <= cfg_wdata[gwpa_pkg::WLEN_W-1:0];
						slot_q <= '0;
						fill_q <= '0;
						cnt_q  <= '0;
						for (int k = 0; k < 3; k++) begin
							sum_q[k] <= '0;
						end
					end
					gwpa_pkg::REG_SPEED_THRESHOLD: begin
						thr_q <= cfg_wdata[gwpa_pkg::THR_W-1:0];
					end
					gwpa_pkg::REG_FRACTION_TENTHS: begin
						frac_q <= cfg_wdata[gwpa_pkg::FRAC_W-1:0];
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					wfull_q <= (fill_q >= len);
					if ((fill_q >= len) && rd_q[RW-1]) begin
						for (int k = 0; k < 3; k++) begin
							sum_q[k] <= sum_q[k] -
							            SW'($signed(rd_q[k*CW +: CW]));
						end
						cnt_q <= cnt_q - LW'(1);
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (mov_q) begin
						for (int k = 0; k < 3; k++) begin
							sum_q[k] <= sum_q[k] + SW'($signed(fix_q[k]));
						end
						cnt_q <= cnt_q + LW'(1);
					end
					if (LW'(slot_q) + LW'(1) >= len) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + SLW'(1);
					end
					if (!wfull_q) begin
						fill_q <= fill_q + LW'(1);
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					fresh_q <= gate_ok;
					div_q   <= cnt_q;
					axis_q  <= '0;
					state_q <= gate_ok ? ST_LOAD : ST_OUT;
				end
				ST_LOAD: begin
					neg_q   <= sum_sel[SW-1];
					dvd_q   <= sum_sel[SW-1] ? (~sum_sel + SW'(1)) : sum_sel;
					rem_q   <= '0;
					bit_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dvd_q <= {dvd_q[SW-2:0], q_bit};
					rem_q <= rem_nx[LW-1:0];
					bit_q <= bit_q + BW'(1);
					if (bit_q == BW'(SW - 1)) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					held_q[axis_q] <= neg_q ? (~quo + CW'(1)) : quo;
					axis_q         <= axis_q + 2'd1;
					state_q        <= (axis_q == 2'd2) ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (out_free) begin
						for (int k = 0; k < 3; k++) begin
							out_avg_q[k] <= (fill_q >= len) ? held_q[k] : '0;
						end
						out_full_q  <= wfull_q;
						out_fresh_q <= fresh_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{gwpa_pkg::OUT_PAD_W{1'b0}}, out_fresh_q, out_full_q,
	                        out_avg_q[2], out_avg_q[1], out_avg_q[0]};

	a_cnt_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fill_q)
		else $error("moving count above fill count");

	a_fill_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len)
		else $error("fill count above window length");

	a_slot_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(slot_q) < len)
		else $error("write slot outside window");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != '0))
		else $error("divide by zero moving count");

endmodule

`default_nettype wire

@@ sim/gated_window_position_average_tb.sv @@
`timescale 1ns / 1ps
// Testbench for gated_window_position_average: a directed table of fixes, then random phases.
// Results are checked against a local model (window, sums, held estimate) or a table value.
// Depends on gwpa_pkg and the block itself.

module gated_window_position_average_tb;
	import gwpa_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [COORD_W-1:0] MAX32 = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] MIN32 = 32'sh8000_0000;
	localparam logic signed [SPEED_W-1:0] MAXS = 16'sh7FFF;
	localparam logic signed [SPEED_W-1:0] MINS = 16'sh8000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 200;
	localparam int N_PHASES = 12;
	localparam int PHASE_ITEMS = 163;

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		logic signed [COORD_W-1:0] up;
		logic signed [COORD_W-1:0] north;
		logic signed [COORD_W-1:0] east;
	} fix_t;

	typedef struct packed {
		logic [OUT_PAD_W-1:0]      pad;
		logic                      valid;
		logic                      full;
		logic signed [COORD_W-1:0] up;
		logic signed [COORD_W-1:0] north;
		logic signed [COORD_W-1:0] east;
	} avg_t;

	typedef struct {
		logic [3:0]            cfg_mask;
		logic [CFG_DATA_W-1:0] wl;
		logic [CFG_DATA_W-1:0] thr;
		logic [CFG_DATA_W-1:0] frac;
		fix_t                  fix;
		bit                    typed;
		avg_t                  want;
	} step_row_t;

	localparam avg_t NO_AVG = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int err_count = 0;

	avg_t pending_avg_q[$];

	logic [WLEN_W-1:0] wl_reg = WLEN_RST;
	logic [THR_W-1:0] thr_reg = THR_RST;
	logic [FRAC_W-1:0] frac_reg = FRAC_RST;
	longint ring_e[MAX_WINDOW_DEF];
	longint ring_n[MAX_WINDOW_DEF];
	longint ring_u[MAX_WINDOW_DEF];
	bit mov_ring[MAX_WINDOW_DEF];
	int unsigned wr_slot = 0;
	int unsigned fill_cnt = 0;
	int unsigned mov_cnt = 0;
	longint sum_e = 0;
	longint sum_n = 0;
	longint sum_u = 0;
	longint held_e = 0;
	longint held_n = 0;
	longint held_u = 0;

	gated_window_position_average i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic fix_t mk_fix(input logic signed [COORD_W-1:0] e, n, u,
			input logic signed [SPEED_W-1:0] s);
		fix_t f;
		f.east = e;
		f.north = n;
		f.up = u;
		f.speed = s;
		return f;
	endfunction

	function automatic avg_t mk_avg(input logic signed [COORD_W-1:0] e, n, u,
			input logic full, valid);
		avg_t r;
		r = '0;
		r.east = e;
		r.north = n;
		r.up = u;
		r.full = full;
		r.valid = valid;
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: return MAX32;
			1: return MIN32;
			2, 3: return int'($urandom_range(40)) - 20;
			default: return $urandom;
		endcase
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_WINDOW_LEN: begin
				wl_reg = d[WLEN_W-1:0];
				wr_slot = 0;
				fill_cnt = 0;
				mov_cnt = 0;
				sum_e = 0;
				sum_n = 0;
				sum_u = 0;
			end
			REG_SPEED_THRESHOLD: thr_reg = d[THR_W-1:0];
			REG_FRACTION_TENTHS: frac_reg = d[FRAC_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic avg_t average_fix(input fix_t f);
		int unsigned len;
		int unsigned slot;
		bit mov;
		bit was_full;
		avg_t r;
		if (wl_reg == 0)
			len = 1;
		else if (wl_reg > MAX_WINDOW_DEF)
			len = MAX_WINDOW_DEF;
		else
			len = wl_reg;
		slot = wr_slot % len;
		mov = int'(f.speed) > int'(thr_reg);
		was_full = fill_cnt >= len;
		if (was_full && mov_ring[slot]) begin
			sum_e -= ring_e[slot];
			sum_n -= ring_n[slot];
			sum_u -= ring_u[slot];
			mov_cnt--;
		end
		ring_e[slot] = f.east;
		ring_n[slot] = f.north;
		ring_u[slot] = f.up;
		mov_ring[slot] = mov;
		if (mov) begin
			sum_e += f.east;
			sum_n += f.north;
			sum_u += f.up;
			mov_cnt++;
		end
		wr_slot = (slot + 1 >= len) ? 0 : slot + 1;
		if (!was_full)
			fill_cnt++;
		r = '0;
		if (fill_cnt >= len) begin
			if (mov_cnt * 10 > len * frac_reg && mov_cnt != 0) begin
				held_e = sum_e / longint'(mov_cnt);
				held_n = sum_n / longint'(mov_cnt);
				held_u = sum_u / longint'(mov_cnt);
				r.valid = 1'b1;
			end
			r.east = held_e[COORD_W-1:0];
			r.north = held_n[COORD_W-1:0];
			r.up = held_u[COORD_W-1:0];
		end
		r.full = was_full;
		return r;
	endfunction

	task automatic write_one(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		apply_reg(idx, d);
	endtask

	task automatic write_regs(input logic [3:0] mask, input logic [CFG_DATA_W-1:0] wl, thr, frac);
		if (mask[0])
			write_one(REG_WINDOW_LEN, wl);
		if (mask[1])
			write_one(REG_SPEED_THRESHOLD, thr);
		if (mask[2])
			write_one(REG_FRACTION_TENTHS, frac);
		if (mask[3])
			write_one(REG_UNUSED, ~wl);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_avg_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic offer_fix(input fix_t f, input bit typed, input avg_t want);
		avg_t pred;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		do @(posedge clk); while (!s_axis_tready);
		pred = average_fix(f);
		pending_avg_q.insert(pending_avg_q.size(), typed ? want : pred);
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : check_result
		avg_t got;
		avg_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = avg_t'(m_axis_tdata);
			if (pending_avg_q.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, actual %h", $time, got);
			end else begin
				want = pending_avg_q.pop_front();
				if (got.east !== want.east || got.north !== want.north || got.up !== want.up ||
						got.full !== want.full || got.valid !== want.valid) begin
					err_count++;
					$display("%0t: expected e=%0d n=%0d u=%0d full=%0b valid=%0b, %s",
						$time, want.east, want.north, want.up, want.full, want.valid,
						$sformatf("actual e=%0d n=%0d u=%0d full=%0b valid=%0b",
						got.east, got.north, got.up, got.full, got.valid));
				end
			end
		end
	end

	initial begin : stimulus
		step_row_t rows[$];
		logic [CFG_DATA_W-1:0] wl;
		logic [CFG_DATA_W-1:0] thr;
		logic [CFG_DATA_W-1:0] frac;
		int spd;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.insert(rows.size(), '{4'b1111, 15'd3, 15'd100, 15'd1,
			mk_fix(MAX32, MIN32, 0, MAXS), 1'b1, NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(MIN32, MAX32, -1, MINS), 1'b1,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0,
			mk_fix(MAX32, MAX32, MAX32, 16'sd100), 1'b0, NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0,
			mk_fix(MAX32, MAX32, MAX32, 16'sd101), 1'b0, NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(MIN32, MIN32, MIN32, MAXS), 1'b0,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(MIN32, MIN32, MIN32, MAXS), 1'b0,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(-7, 7, -1, 16'sd200), 1'b0,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0100, '0, '0, 15'd10, mk_fix(5, 5, 5, MAXS), 1'b0,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0100, '0, '0, 15'd15, mk_fix(-5, -5, -5, MAXS), 1'b0,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0101, 15'd0, '0, 15'd0, mk_fix(123, -456, 789, MAXS),
			1'b1, mk_avg(123, -456, 789, 1'b0, 1'b1)});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(1, 2, 3, MINS), 1'b1,
			mk_avg(123, -456, 789, 1'b1, 1'b0)});
		rows.insert(rows.size(), '{4'b0001, 15'h7FFF, '0, '0, mk_fix(9, 9, 9, MAXS), 1'b1,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0011, 15'd2, 15'h7FFF, '0,
			mk_fix(MAX32, MAX32, MAX32, MAXS), 1'b1, NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(MIN32, MIN32, MIN32, MAXS), 1'b1,
			mk_avg(123, -456, 789, 1'b0, 1'b0)});
		rows.insert(rows.size(), '{4'b0010, '0, 15'd0, '0, mk_fix(-1000, 1000, 0, 16'sd1),
			1'b0, NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(3, -3, 0, 16'sd0), 1'b0,
			NO_AVG});
		rows.insert(rows.size(), '{4'b0000, '0, '0, '0, mk_fix(0, 0, 0, 16'sh8001), 1'b0,
			NO_AVG});

		tx_idle_pct = 33;
		rx_stall_pct <= 33;
		foreach (rows[i]) begin
			if (rows[i].cfg_mask != 0) begin
				settle();
				write_regs(rows[i].cfg_mask, rows[i].wl, rows[i].thr, rows[i].frac);
			end
			offer_fix(rows[i].fix, rows[i].typed, rows[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			case (p)
				0: begin wl = 15'd4; thr = 15'd278; frac = 15'd1; end
				1: begin wl = 15'd1; thr = 15'd0; frac = 15'd0; end
				2: begin wl = 15'd32; thr = 15'd278; frac = 15'd5; end
				3: begin wl = 15'd33; thr = 15'd1000; frac = 15'd9; end
				4: begin wl = 15'd0; thr = 15'h7FFF; frac = 15'd0; end
				5: begin wl = 15'd7; thr = 15'd0; frac = 15'd10; end
				6: begin wl = 15'h7FC5; thr = 15'd20000; frac = 15'h7FF3; end
				default: begin
					wl = 15'($urandom_range(40));
					thr = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(2000));
					frac = 15'($urandom_range(15));
				end
			endcase
			case (p % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct <= 0; end
				1: begin tx_idle_pct = 64; rx_stall_pct <= 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct <= 64; end
				default: begin tx_idle_pct = 33; rx_stall_pct <= 33; end
			endcase
			write_regs(4'b0111, wl, thr, frac);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 0 && k == 20)
					hold_req <= 1'b1;
				if (p % 3 == 2 && k == PHASE_ITEMS / 2) begin
					settle();
					write_regs(4'b0010, '0, 15'($urandom_range(1500)), '0);
				end
				case ($urandom_range(9))
					0, 1, 2: spd = int'(thr_reg) + int'($urandom_range(4)) - 2;
					3, 4, 5, 6: spd = int'($urandom_range(32767, thr_reg));
					default: spd = int'($urandom_range(65535)) - 32768;
				endcase
				if (spd > 32767)
					spd = 32767;
				offer_fix(mk_fix(rand_coord(), rand_coord(), rand_coord(), spd[SPEED_W-1:0]),
					1'b0, NO_AVG);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
